FILE: rtl/swer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window error rate: shared package
// Field widths, codes, the control word layout and the microcode program.
// ----------------------------------------------------------------------------
package swer_pkg;

  localparam int PC_W      = 4;
  localparam int CNT_W     = 6;
  localparam int TIME_W    = 48;
  localparam int CNT_BITS  = 32;
  localparam int RATE_W    = 17;
  localparam int OUT_SUM_W = 36;
  localparam int ACT_W     = 2;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 96;
  localparam int CFG_W     = 32;
  localparam int BMS_W     = 16;

  localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic CFG_BUCKET_MS = 1'b0;
  localparam logic CFG_VOLUME    = 1'b1;

  localparam logic [BMS_W-1:0] BUCKET_MS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] VOLUME_RST    = 32'd10;

  // Datapath operations.
  localparam logic [3:0] OP_NOP         = 4'd0;
  localparam logic [3:0] OP_TDIV_INIT   = 4'd1;
  localparam logic [3:0] OP_DIV_STEP    = 4'd2;
  localparam logic [3:0] OP_DIV_STEP_NS = 4'd3;
  localparam logic [3:0] OP_REC_RD      = 4'd4;
  localparam logic [3:0] OP_REC_WR      = 4'd5;
  localparam logic [3:0] OP_QINIT       = 4'd6;
  localparam logic [3:0] OP_QREAD       = 4'd7;
  localparam logic [3:0] OP_QACC        = 4'd8;
  localparam logic [3:0] OP_RDIV_INIT   = 4'd9;
  localparam logic [3:0] OP_EMIT        = 4'd10;
  localparam logic [3:0] OP_CLEAR       = 4'd11;

  // Loop counter loads.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_TIME = 2'd1;
  localparam logic [1:0] CNT_WALK = 2'd2;
  localparam logic [1:0] CNT_RATE = 2'd3;

  localparam logic [CNT_W-1:0] TIME_LAST = 6'd47;
  localparam logic [CNT_W-1:0] RATE_LAST = 6'd15;

  // Sequencing conditions.
  localparam logic [2:0] COND_NEXT    = 3'd0;
  localparam logic [2:0] COND_ALWAYS  = 3'd1;
  localparam logic [2:0] COND_CNT_NZ  = 3'd2;
  localparam logic [2:0] COND_QUERY   = 3'd3;
  localparam logic [2:0] COND_NO_RATE = 3'd4;
  localparam logic [2:0] COND_WAIT    = 3'd5;

  // Program addresses.
  localparam logic [PC_W-1:0] ADDR_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ADDR_TDIV   = 4'd1;
  localparam logic [PC_W-1:0] ADDR_TLOOP  = 4'd2;
  localparam logic [PC_W-1:0] ADDR_BRANCH = 4'd3;
  localparam logic [PC_W-1:0] ADDR_RREAD  = 4'd4;
  localparam logic [PC_W-1:0] ADDR_RWRITE = 4'd5;
  localparam logic [PC_W-1:0] ADDR_QINIT  = 4'd6;
  localparam logic [PC_W-1:0] ADDR_QREAD  = 4'd7;
  localparam logic [PC_W-1:0] ADDR_QACC   = 4'd8;
  localparam logic [PC_W-1:0] ADDR_RINIT  = 4'd9;
  localparam logic [PC_W-1:0] ADDR_RFIRST = 4'd10;
  localparam logic [PC_W-1:0] ADDR_RLOOP  = 4'd11;
  localparam logic [PC_W-1:0] ADDR_EMIT   = 4'd12;
  localparam logic [PC_W-1:0] ADDR_CLEAR  = 4'd13;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      cnt_ld;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic is_query;
    logic no_rate;
    logic emit_block;
  } st_t;

  typedef struct packed {
    logic [TIME_W-1:0]   tag;
    logic [CNT_BITS-1:0] req;
    logic [CNT_BITS-1:0] fail;
  } entry_t;

  function automatic cw_t cw_make(input logic [3:0] op, input logic [1:0] cnt_ld,
                                  input logic [2:0] cond, input logic [PC_W-1:0] target);
    cw_t w;
    w.op     = op;
    w.cnt_ld = cnt_ld;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic cw_t uc_rom(input logic [PC_W-1:0] addr);
    cw_t w;
    case (addr)
      ADDR_IDLE:   w = cw_make(OP_NOP,         CNT_NONE, COND_WAIT,    ADDR_IDLE);
      ADDR_TDIV:   w = cw_make(OP_TDIV_INIT,   CNT_TIME, COND_NEXT,    ADDR_IDLE);
      ADDR_TLOOP:  w = cw_make(OP_DIV_STEP,    CNT_NONE, COND_CNT_NZ,  ADDR_TLOOP);
      ADDR_BRANCH: w = cw_make(OP_NOP,         CNT_NONE, COND_QUERY,   ADDR_QINIT);
      ADDR_RREAD:  w = cw_make(OP_REC_RD,      CNT_NONE, COND_NEXT,    ADDR_IDLE);
      ADDR_RWRITE: w = cw_make(OP_REC_WR,      CNT_NONE, COND_ALWAYS,  ADDR_IDLE);
      ADDR_QINIT:  w = cw_make(OP_QINIT,       CNT_WALK, COND_NEXT,    ADDR_IDLE);
      ADDR_QREAD:  w = cw_make(OP_QREAD,       CNT_NONE, COND_NEXT,    ADDR_IDLE);
      ADDR_QACC:   w = cw_make(OP_QACC,        CNT_NONE, COND_CNT_NZ,  ADDR_QACC);
      ADDR_RINIT:  w = cw_make(OP_RDIV_INIT,   CNT_NONE, COND_NO_RATE, ADDR_EMIT);
      ADDR_RFIRST: w = cw_make(OP_DIV_STEP_NS, CNT_RATE, COND_NEXT,    ADDR_IDLE);
      ADDR_RLOOP:  w = cw_make(OP_DIV_STEP,    CNT_NONE, COND_CNT_NZ,  ADDR_RLOOP);
      ADDR_EMIT:   w = cw_make(OP_EMIT,        CNT_NONE, COND_ALWAYS,  ADDR_IDLE);
      ADDR_CLEAR:  w = cw_make(OP_CLEAR,       CNT_NONE, COND_ALWAYS,  ADDR_IDLE);
      default:     w = cw_make(OP_NOP,         CNT_NONE, COND_ALWAYS,  ADDR_IDLE);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/swer_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/swer_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window error rate: microcode sequencer
// Step counter, loop counter and conditional jumps over the program ROM.
// ----------------------------------------------------------------------------
module swer_seq #(
  parameter int BUCKETS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [swer_pkg::ACT_W-1:0] action,
  input  swer_pkg::st_t            st,
  output swer_pkg::cw_t            cw,
  output logic                     idle
);
  import swer_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign cw   = uc_rom(pc);
  assign idle = (pc == ADDR_IDLE);

  always_comb begin
    pc_next = pc + PC_W'(1);
    case (cw.cond)
      COND_NEXT: ;
      COND_ALWAYS: pc_next = cw.target;
      COND_CNT_NZ: begin
        if (cnt != '0) pc_next = cw.target;
      end
      COND_QUERY: begin
        if (st.is_query) pc_next = cw.target;
      end
      COND_NO_RATE: begin
        if (st.no_rate) pc_next = cw.target;
      end
      COND_WAIT: begin
        pc_next = pc;
        if (accept) begin
          if (action inside {ACT_RECORD, ACT_QUERY}) pc_next = ADDR_TDIV;
          else if (action == ACT_CLEAR) pc_next = ADDR_CLEAR;
        end
      end
      default: pc_next = ADDR_IDLE;
    endcase
    // A finished result waits here until the output register is free.
    if (cw.op == OP_EMIT && st.emit_block) pc_next = pc;
  end

  always_comb begin
    cnt_next = cnt;
    if (cw.cond == COND_CNT_NZ && cnt != '0) cnt_next = cnt - CNT_W'(1);
    case (cw.cnt_ld)
      CNT_NONE: ;
      CNT_TIME: cnt_next = TIME_LAST;
      CNT_WALK: cnt_next = CNT_W'(BUCKETS - 1);
      CNT_RATE: cnt_next = RATE_LAST;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= ADDR_IDLE;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT && !st.emit_block) |=> idle)
    else $error("sequencer did not return to idle after emitting a result");

  a_loop_exit: assert property (@(posedge clk) disable iff (rst)
    (cw.cond == COND_CNT_NZ && cnt == '0) |=> (pc == $past(pc) + PC_W'(1)))
    else $error("loop did not fall through when its counter ran out");

  a_clear_dispatch: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_CLEAR) |=> (pc == ADDR_CLEAR))
    else $error("clear word not dispatched to the clear step");
`endif

endmodule
`default_nettype wire

FILE: rtl/swer_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window error rate: datapath
// Shared restoring divider, bucket store, window sums and output register.
// ----------------------------------------------------------------------------
module swer_dp #(
  parameter int BUCKETS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  swer_pkg::cw_t              cw,
  input  logic                       accept,
  input  logic [swer_pkg::ACT_W-1:0] in_action,
  input  logic [swer_pkg::TIME_W-1:0] in_now,
  input  logic                       in_success,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [swer_pkg::CFG_W-1:0] cfg_data,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [swer_pkg::OUT_W-1:0] m_tdata,
  output swer_pkg::st_t              st
);
  import swer_pkg::*;

  localparam int IDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SUM_NEED = CNT_BITS + $clog2(BUCKETS);
  localparam int ACC_W    = (SUM_NEED > OUT_SUM_W) ? SUM_NEED : OUT_SUM_W;
  localparam int REM_W    = ACC_W + 1;
  localparam int ENTRY_W  = $bits(entry_t);
  localparam int PAD_W    = OUT_W - RATE_W - 2 * OUT_SUM_W - 1;

  logic [BMS_W-1:0]  bucket_ms;
  logic [CFG_W-1:0]  volume_threshold;
  logic [ACT_W-1:0]  act;
  logic              success_q;
  logic [BUCKETS-1:0] valid;

  logic [REM_W-1:0]  rem;
  logic [TIME_W-1:0] dvd;
  logic [ACC_W-1:0]  dsr;
  logic [IDX_W-1:0]  modacc;
  logic [IDX_W-1:0]  wptr;
  logic [ACC_W-1:0]  acc_total;
  logic [ACC_W-1:0]  acc_errs;
  logic              rd_valid;
  logic              met_q;

  logic [RATE_W-1:0]    out_rate;
  logic [OUT_SUM_W-1:0] out_total;
  logic [OUT_SUM_W-1:0] out_errs;
  logic                 out_met;

  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_sub;
  logic              q_bit;
  logic [IDX_W:0]    mod_dbl;
  logic [IDX_W:0]    mod_red;
  logic [IDX_W-1:0]  mod_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  entry_t            wr_entry;

  logic              hit;
  logic [CNT_BITS-1:0] base_req;
  logic [CNT_BITS-1:0] base_fail;
  logic              in_win;
  logic              met;
  logic [ACC_W-1:0]  err_cap;
  logic [BMS_W-1:0]  bucket_len;
  logic              emit_block;

  function automatic logic [OUT_SUM_W-1:0] sat_sum(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] hi;
    hi = v >> OUT_SUM_W;
    if (hi != '0) return '1;
    return v[OUT_SUM_W-1:0];
  endfunction

  // Shared divider: one quotient bit per step.
  assign trial   = (cw.op == OP_DIV_STEP_NS) ? rem : {rem[REM_W-2:0], dvd[TIME_W-1]};
  assign q_bit   = (trial >= {1'b0, dsr});
  assign rem_sub = trial - {1'b0, dsr};

  // Bucket index follows the quotient bits as they appear, highest first.
  assign mod_dbl  = {modacc, q_bit};
  assign mod_red  = (mod_dbl >= (IDX_W + 1)'(BUCKETS)) ? mod_dbl - (IDX_W + 1)'(BUCKETS)
                                                        : mod_dbl;
  assign mod_next = mod_red[IDX_W-1:0];

  assign bucket_len = (bucket_ms == '0) ? BMS_W'(1) : bucket_ms;

  assign rd_entry  = entry_t'(ram_rdata);
  assign ram_we    = (cw.op == OP_REC_WR);
  assign ram_raddr = (cw.op == OP_QREAD || cw.op == OP_QACC) ? wptr : modacc;

  assign hit       = valid[modacc] && (rd_entry.tag == dvd);
  assign base_req  = hit ? rd_entry.req : '0;
  assign base_fail = hit ? rd_entry.fail : '0;

  always_comb begin
    wr_entry.tag  = dvd;
    wr_entry.req  = (base_req == '1) ? base_req : base_req + CNT_BITS'(1);
    wr_entry.fail = (!success_q && base_fail != '1) ? base_fail + CNT_BITS'(1) : base_fail;
  end

  assign in_win  = rd_valid &&
                   (({1'b0, rd_entry.tag} + (TIME_W + 1)'(BUCKETS)) > {1'b0, dvd});
  assign met     = (acc_total >= {{(ACC_W - CFG_W){1'b0}}, volume_threshold});
  assign err_cap = (acc_errs > acc_total) ? acc_total : acc_errs;

  assign emit_block    = m_tvalid && !m_tready;
  assign st.is_query   = (act == ACT_QUERY);
  assign st.no_rate    = !met || (acc_total == '0);
  assign st.emit_block = emit_block;

  assign m_tdata = {{PAD_W{1'b0}}, out_met, out_errs, out_total, out_rate};

  swer_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (modacc),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_ms        <= BUCKET_MS_RST;
      volume_threshold <= VOLUME_RST;
      valid            <= '0;
      m_tvalid         <= 1'b0;
      modacc           <= '0;
      wptr             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUCKET_MS: bucket_ms <= cfg_data[BMS_W-1:0];
          CFG_VOLUME:    volume_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (cw.op == OP_EMIT && !emit_block) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cw.op)
        OP_TDIV_INIT: modacc <= '0;
        OP_DIV_STEP, OP_DIV_STEP_NS: modacc <= mod_next;
        OP_REC_WR: valid[modacc] <= 1'b1;
        OP_QINIT: wptr <= '0;
        OP_QREAD, OP_QACC: begin
          if (wptr != IDX_W'(BUCKETS - 1)) wptr <= wptr + IDX_W'(1);
        end
        OP_CLEAR: valid <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[ram_raddr];
    if (accept) begin
      act       <= in_action;
      success_q <= in_success;
      dvd       <= in_now;
    end
    case (cw.op)
      OP_TDIV_INIT: begin
        rem <= '0;
        dsr <= {{(ACC_W - BMS_W){1'b0}}, bucket_len};
      end
      OP_DIV_STEP, OP_DIV_STEP_NS: begin
        rem <= q_bit ? rem_sub : trial;
        dvd <= {dvd[TIME_W-2:0], q_bit};
      end
      OP_QINIT: begin
        acc_total <= '0;
        acc_errs  <= '0;
      end
      OP_QACC: begin
        if (in_win) begin
          acc_total <= acc_total + {{(ACC_W - CNT_BITS){1'b0}}, rd_entry.req};
          acc_errs  <= acc_errs + {{(ACC_W - CNT_BITS){1'b0}}, rd_entry.fail};
        end
      end
      OP_RDIV_INIT: begin
        rem   <= {1'b0, err_cap};
        dsr   <= acc_total;
        dvd   <= '0;
        met_q <= met;
      end
      OP_EMIT: begin
        if (!emit_block) begin
          out_rate  <= dvd[RATE_W-1:0];
          out_total <= sat_sum(acc_total);
          out_errs  <= sat_sum(acc_errs);
          out_met   <= met_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_REC_WR) |=> valid[$past(modacc)])
    else $error("bucket not marked valid after a record write");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_rate <= ONE_Q16))
    else $error("error rate above one");

  a_rate_needs_volume: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_met) |-> (out_rate == '0))
    else $error("nonzero error rate below the volume threshold");
`endif

endmodule
`default_nettype wire

FILE: rtl/sliding_window_error_rate.sv
`timescale 1ns / 1ps
`default_nettype none
// Record words run the 48-step division of the time by the bucket length,
// then read and update the bucket. Query words run that division, the sums
// over the buckets and 17 divider steps for the rate, which are skipped below
// the threshold or with no requests; a held result stalls the next query at
// its last step. Clear empties all buckets; an unused action does nothing.
// Reset is synchronous: all buckets empty and both registers at their defaults.
// ----------------------------------------------------------------------------
// Sliding window error rate counter
// Ring of time buckets with request and error counts, queried over a window,
// controlled by a microcoded sequencer over a shared divider datapath.
// ----------------------------------------------------------------------------
module sliding_window_error_rate #(
  parameter int BUCKETS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [swer_pkg::IN_W-1:0]   s_tdata,   // now_ms [47:0], success [48], zero pad
  input  logic [swer_pkg::ACT_W-1:0]  s_tuser,   // action [1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [swer_pkg::OUT_W-1:0]  m_tdata,   // error_rate [16:0], window_total [52:17],
                                                 // window_errors [88:53], volume_met [89],
                                                 // zero pad
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [swer_pkg::CFG_W-1:0]  cfg_data
);
  import swer_pkg::*;

  cw_t  cw;
  st_t  st;
  logic idle;
  logic accept;

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;

  swer_seq #(
    .BUCKETS(BUCKETS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (s_tuser),
    .st     (st),
    .cw     (cw),
    .idle   (idle)
  );

  swer_dp #(
    .BUCKETS(BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cw         (cw),
    .accept     (accept),
    .in_action  (s_tuser),
    .in_now     (s_tdata[TIME_W-1:0]),
    .in_success (s_tdata[TIME_W]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .st         (st)
  );

endmodule
`default_nettype wire
